// ----- hdl/sctrf_pkg.sv -----
`timescale 1ns / 1ps

package sctrf_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 12;
	localparam int unsigned KIND_W = 4;
	localparam int unsigned INDEX_W = ADDR_W - KIND_W;
	localparam int unsigned SIZE_W = 2;

	// Write kinds selected by the low address nibble
	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE  = 4'h0,
		KIND_SET    = 4'h4,
		KIND_CLEAR  = 4'h8,
		KIND_TOGGLE = 4'hC
	} kind_t;

	// Size codes
	localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
	localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd3;

	// Action codes
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Modify request handed to the update unit
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SIZE_W-1:0] size_code;
		logic [DATA_W-1:0] data;
	} upd_req_t;

endpackage

// ----- hdl/sctrf_update.sv -----
`timescale 1ns / 1ps

module sctrf_update (
	input  sctrf_pkg::upd_req_t          req,
	input  logic [sctrf_pkg::DATA_W-1:0] old_value,
	output logic [sctrf_pkg::DATA_W-1:0] new_value
);
	import sctrf_pkg::*;

	logic [DATA_W-1:0] mask;
	logic [DATA_W-1:0] merged;

	// Select the part of the register the write acts on
	always_comb begin
		unique case (req.size_code)
			SIZE_WORD: mask = {DATA_W{1'b1}};
			SIZE_HALF: mask = {{(DATA_W/2){1'b0}}, {(DATA_W/2){1'b1}}};
			default:   mask = {{(DATA_W-8){1'b0}}, 8'hFF};
		endcase
	end

	// Apply the write kind; unlisted kinds are plain writes
	always_comb begin
		unique case (req.kind)
			KIND_SET:    merged = old_value | req.data;
			KIND_CLEAR:  merged = old_value & ~req.data;
			KIND_TOGGLE: merged = old_value ^ req.data;
			default:     merged = req.data;
		endcase
	end

	// Keep bits outside the selected part
	assign new_value = (old_value & ~mask) | (merged & mask);

endmodule

// ----- hdl/set_clear_toggle_register_file.sv -----
`timescale 1ns / 1ps
// Read path: stage 1 register, then the output register that drives the master side.
// Throughput: one access per cycle while the read result side does not stall; the memory
// read of one access overlaps the write back of the previous one, with forwarding when both hit the same entry.
// Reset: arst_n clears all control state and the per-entry valid bits, so every
// register reads as zero until written; no clearing pass is needed.

module set_clear_toggle_register_file #(
	parameter int unsigned NUM_REGS = 178
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [11:0] address, [43:12] write_data, [45:44] size_code, [47:46] zero
	input  logic [47:0] s_axis_tdata,
	// [0] action
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] read_data
	output logic [31:0] m_axis_tdata
);
	import sctrf_pkg::*;

	localparam int unsigned MEM_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	// Input field decode
	logic [ADDR_W-1:0]  in_address;
	logic [DATA_W-1:0]  in_data;
	logic [SIZE_W-1:0]  in_size;
	logic [INDEX_W-1:0] in_index;
	logic [MEM_AW-1:0]  in_mem_addr;
	logic               in_range;
	logic               in_xfer;

	assign in_address  = s_axis_tdata[ADDR_W-1:0];
	assign in_data     = s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
	assign in_size     = s_axis_tdata[ADDR_W+DATA_W+SIZE_W-1:ADDR_W+DATA_W];
	assign in_index    = in_address[ADDR_W-1:KIND_W];
	assign in_mem_addr = MEM_AW'(in_index);
	assign in_range    = {1'b0, in_index} < (INDEX_W+1)'(NUM_REGS);
	assign in_xfer     = s_axis_tvalid && s_axis_tready;

	// Stage 1 registers
	logic               valid_s1;
	logic               write_s1;
	logic               range_s1;
	logic [MEM_AW-1:0]  addr_s1;
	upd_req_t           req_s1;
	logic [DATA_W-1:0]  mem_rd_s1;
	logic               entry_vld_s1;
	logic               fwd_s1;
	logic [DATA_W-1:0]  fwd_data_s1;

	// Output register
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;

	// Storage
	logic [DATA_W-1:0]  mem [NUM_REGS];
	logic [NUM_REGS-1:0] entry_vld_q;

	logic               adv_s1;
	logic               wr_en;
	logic [DATA_W-1:0]  old_value;
	logic [DATA_W-1:0]  new_value;
	logic               fwd_hit;

	// Stage 1 may retire when it holds a write or a read result has room
	assign adv_s1        = valid_s1 && (write_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign wr_en         = adv_s1 && write_s1 && range_s1;
	assign fwd_hit       = wr_en && (addr_s1 == in_mem_addr);

	// Pick the freshest value of the entry
	always_comb begin
		if (fwd_s1) begin
			old_value = fwd_data_s1;
		end else if (entry_vld_s1) begin
			old_value = mem_rd_s1;
		end else begin
			old_value = '0;
		end
	end

	sctrf_update u_update (
		.req       (req_s1),
		.old_value (old_value),
		.new_value (new_value)
	);

	// Memory read on acceptance, write back from stage 1
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= new_value;
		end
		if (in_xfer) begin
			mem_rd_s1 <= mem[in_mem_addr];
		end
	end

	// Valid bits: cleared at reset, set on first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
		end else if (wr_en) begin
			entry_vld_q[addr_s1] <= 1'b1;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Stage 1 payload, with forwarding of a same-entry write back
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			write_s1          <= (s_axis_tuser == ACT_WRITE);
			range_s1          <= in_range;
			addr_s1           <= in_mem_addr;
			req_s1.kind       <= in_address[KIND_W-1:0];
			req_s1.size_code  <= in_size;
			req_s1.data       <= in_data;
			entry_vld_s1      <= entry_vld_q[in_mem_addr];
			fwd_s1            <= fwd_hit;
			fwd_data_s1       <= new_value;
		end
	end

	// Output register: load a read result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && !write_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && !write_s1) begin
			out_data_q <= range_s1 ? old_value : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- tb/sv/set_clear_toggle_register_file_tb.sv -----
`timescale 1ns / 1ps

module set_clear_toggle_register_file_tb;

	import sctrf_pkg::*;

	localparam int unsigned NUM_REGS = 178;

	// Shadow copy of the register bank and the queue of read data still owed
	class regfile_scoreboard;
		logic [DATA_W-1:0] bank_model [NUM_REGS];
		logic [DATA_W-1:0] expected_reads [$];
		int errors;

		function new();
			foreach (bank_model[i]) bank_model[i] = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_reads.size();
		endfunction

		// Update the shadow bank for an accepted access, or queue the read data
		function void note_access(logic act, logic [ADDR_W-1:0] addr,
				logic [DATA_W-1:0] data, logic [SIZE_W-1:0] size);
			logic [INDEX_W-1:0] idx;
			logic [DATA_W-1:0] part;
			logic [DATA_W-1:0] old;
			logic [DATA_W-1:0] modified;
			idx = addr[ADDR_W-1:KIND_W];
			if (act == ACT_READ) begin
				expected_reads.push_back(idx < NUM_REGS ? bank_model[idx] : '0);
				return;
			end
			// Writes beyond the bank change nothing
			if (idx >= NUM_REGS)
				return;
			case (size)
				SIZE_WORD: part = 32'hFFFF_FFFF;
				SIZE_HALF: part = 32'h0000_FFFF;
				default:   part = 32'h0000_00FF;
			endcase
			old = bank_model[idx];
			case (addr[KIND_W-1:0])
				KIND_SET:    modified = old | data;
				KIND_CLEAR:  modified = old & ~data;
				KIND_TOGGLE: modified = old ^ data;
				default:     modified = data;
			endcase
			bank_model[idx] = (old & ~part) | (modified & part);
		endfunction

		task report(string msg);
			$display("[%0t] error: %s", $realtime, msg);
			errors++;
		endtask

		// Compare one read transfer with the oldest queued read data
		task check_read(logic [DATA_W-1:0] got);
			logic [DATA_W-1:0] want;
			if (expected_reads.size() == 0) begin
				report($sformatf("read data %h arrived with no read pending", got));
				return;
			end
			want = expected_reads.pop_front();
			if (got !== want)
				report($sformatf("read_data got %h want %h", got, want));
		endtask

		task check_drained();
			if (expected_reads.size() != 0)
				report($sformatf("%0d reads never returned", expected_reads.size()));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [47:0]         s_axis_tdata = '0;
	logic                s_axis_tuser = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [DATA_W-1:0]   m_axis_tdata;

	regfile_scoreboard sb;
	bit hold_off_req = 1'b0;
	bit rx_steady = 1'b0;

	set_clear_toggle_register_file #(
		.NUM_REGS(NUM_REGS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Offer one access after a gap and hold it until the transfer
	task automatic send_access(input logic act, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data, input logic [SIZE_W-1:0] size, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, size, data, addr};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_random(input int gap);
		logic act;
		logic [INDEX_W-1:0] idx;
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] data;
		int r;
		act = ($urandom_range(99) < 45) ? ACT_READ : ACT_WRITE;
		// Favor a few entries so that reads and writes collide
		r = $urandom_range(99);
		if (r < 40)
			idx = INDEX_W'($urandom_range(3));
		else if (r < 52)
			idx = INDEX_W'($urandom_range(NUM_REGS - 1, NUM_REGS - 3));
		else if (r < 62)
			idx = INDEX_W'($urandom_range(255, NUM_REGS));
		else
			idx = INDEX_W'($urandom_range(NUM_REGS - 1));
		r = $urandom_range(99);
		if (r < 80) begin
			case ($urandom_range(3))
				0: kind = KIND_WRITE;
				1: kind = KIND_SET;
				2: kind = KIND_CLEAR;
				default: kind = KIND_TOGGLE;
			endcase
		end else begin
			kind = KIND_W'($urandom_range(15));
		end
		r = $urandom_range(99);
		if (r < 10)
			data = 32'hFFFF_FFFF;
		else if (r < 20)
			data = '0;
		else if (r < 35)
			data = 32'h1 << $urandom_range(31);
		else
			data = $urandom;
		send_access(act, {idx, kind}, data, SIZE_W'($urandom_range(3)), gap);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Record accepted accesses
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_access(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[43:12],
				s_axis_tdata[45:44]);
	end

	// Check read transfers
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_read(m_axis_tdata);
	end

	// Drive the result side ready with random stalls and one long hold-off
	initial begin : rx_ready
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				repeat (80) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (rx_steady) begin
				m_axis_tready <= 1'b1;
				stall = 0;
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				stall = idle_gap();
				m_axis_tready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin : stimulus
		int seg;
		int i;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset values, each kind and size, odd kinds, bank edges
		send_access(ACT_READ, 12'h000, 32'h0, 2'd0, idle_gap());
		send_access(ACT_READ, 12'hB10, 32'h0, 2'd0, idle_gap());
		send_access(ACT_WRITE, {8'd0, KIND_WRITE}, 32'hFFFF_FFFF, SIZE_WORD, 0);
		send_access(ACT_READ, 12'h000, 32'h0, 2'd0, 0);
		send_access(ACT_WRITE, {8'd0, KIND_CLEAR}, 32'h0000_F0F0, SIZE_HALF, idle_gap());
		send_access(ACT_READ, 12'h000, 32'h0, 2'd0, idle_gap());
		send_access(ACT_WRITE, {8'd0, KIND_TOGGLE}, 32'h0000_00FF, 2'd0, 0);
		send_access(ACT_READ, 12'h000, 32'h0, 2'd0, 0);
		send_access(ACT_WRITE, {8'd0, KIND_TOGGLE}, 32'hFFFF_FFFF, 2'd2, 0);
		send_access(ACT_READ, 12'h000, 32'h0, 2'd0, idle_gap());
		send_access(ACT_WRITE, {8'd1, KIND_SET}, 32'h8000_0001, SIZE_WORD, idle_gap());
		send_access(ACT_READ, 12'h010, 32'h0, 2'd0, 0);
		send_access(ACT_WRITE, {8'd1, 4'h1}, 32'h1234_5678, SIZE_HALF, 0);
		send_access(ACT_WRITE, {8'd1, 4'hF}, 32'h0000_00AB, 2'd0, 0);
		send_access(ACT_READ, 12'h010, 32'h0, 2'd0, 0);
		send_access(ACT_WRITE, 12'hB10, 32'hA5A5_A5A5, SIZE_WORD, idle_gap());
		send_access(ACT_READ, 12'hB1F, 32'hFFFF_FFFF, 2'd0, 0);
		send_access(ACT_WRITE, 12'hB20, 32'hFFFF_FFFF, SIZE_WORD, idle_gap());
		send_access(ACT_READ, 12'hB20, 32'h0, SIZE_WORD, 0);
		send_access(ACT_WRITE, 12'hFFF, 32'hFFFF_FFFF, SIZE_WORD, 0);
		send_access(ACT_READ, 12'hFFF, 32'h0, SIZE_WORD, 0);
		send_access(ACT_WRITE, {8'd2, KIND_SET}, 32'hFFFF_FFFF, SIZE_HALF, idle_gap());
		send_access(ACT_WRITE, {8'd2, KIND_CLEAR}, 32'h0, SIZE_WORD, 0);
		send_access(ACT_READ, 12'h020, 32'h0, 2'd0, 0);
		send_access(ACT_WRITE, {8'd0, KIND_TOGGLE}, 32'hFFFF_FFFF, SIZE_WORD, 0);
		send_access(ACT_READ, 12'h000, 32'h0, 2'd0, 0);

		// Hold the input until every read has come back
		wait_drained();

		// Random accesses in segments; every third segment runs without idling
		for (seg = 0; seg < 12; seg++) begin
			rx_steady = (seg % 3 == 2);
			for (i = 0; i < 150; i++)
				send_random(rx_steady ? 0 : idle_gap());
			if (seg == 4) begin
				// Stall the result side and keep offering reads until the input backs up
				rx_steady = 1'b0;
				hold_off_req = 1'b1;
				for (i = 0; i < 40; i++)
					send_access(ACT_READ, {8'($urandom_range(NUM_REGS - 1)), 4'h0},
						32'h0, 2'd0, 0);
			end
			if (seg == 7)
				wait_drained();
		end

		rx_steady = 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Give up on a hung run
	initial begin : watchdog
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
